/* src/rpn_stack_evaluator_macros.svh */
// Assertion macros for the RPN stack evaluator checker.
// Used by rse_checker.sv; needs aclk and aresetn in the including scope.
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

// Same-cycle implication, disabled in reset
`define RSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define RSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rse_pkg.sv */
// Shared types and codes for the RPN stack evaluator.
// No dependencies; used by rse_alu and rpn_stack_evaluator.
package rse_pkg;

    // Token kinds as carried on s_tuser
    localparam logic [2:0] KIND_NUM = 3'd0;
    localparam logic [2:0] KIND_ADD = 3'd1;
    localparam logic [2:0] KIND_SUB = 3'd2;
    localparam logic [2:0] KIND_MUL = 3'd3;
    localparam logic [2:0] KIND_DIV = 3'd4;
    localparam logic [2:0] KIND_BAD = 3'd5;

    // Result status codes as carried on m_tuser
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;
    localparam logic [2:0] ST_LEFT  = 3'd5;

    localparam int TOKEN_VALUE_W = 31;
    localparam int RESULT_W      = 32;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [2:0] {
        AST_IDLE,
        AST_ADDSUB,
        AST_MUL,
        AST_NEGA,
        AST_NEGB,
        AST_DIV,
        AST_FIX,
        AST_DONE
    } alu_state_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_POP1,
        SEQ_POP2,
        SEQ_CALC,
        SEQ_CHECK,
        SEQ_READ0,
        SEQ_OUT
    } seq_state_t;

endpackage

/* src/rse_stack.sv */
// Operand stack storage: one write port, one read port with registered data.
// No package dependencies.
module rse_stack #(
    parameter int STACK_DEPTH = 128,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0]          wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0]          rd_data
);

    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Write the pushed entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read entry
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/rse_alu.sv */
// Shared iterative arithmetic unit: add, subtract, shift-add multiply and
// restoring divide, all through one adder. Depends on rse_pkg.
module rse_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rse_pkg::alu_req_t       req,
    input  logic [DATA_WIDTH-1:0]   a,
    input  logic [DATA_WIDTH-1:0]   b,
    output logic                    done,
    output logic [DATA_WIDTH-1:0]   result
);

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(W);

    rse_pkg::alu_state_t state_reg, state_next;
    rse_pkg::alu_op_t    op_reg, op_next;
    logic [W-1:0]        acc_reg, acc_next;
    logic [W-1:0]        opa_reg, opa_next;
    logic [W-1:0]        opb_reg, opb_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_reg, neg_next;

    logic [W-1:0] add_x;
    logic [W-1:0] add_y;
    logic         add_sub;
    logic [W:0]   sum;
    logic [W-1:0] rem_sh;
    logic         last_step;

    // Shared adder; sum[W] is the borrow when subtracting
    assign sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(W + 1){add_sub}}) + (W + 1)'(add_sub);

    assign rem_sh    = {acc_reg[W-2:0], opa_reg[W-1]};
    assign last_step = (cnt_reg == CNT_W'(W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rse_pkg::AST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    // Sequence the shared adder
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        add_x      = acc_reg;
        add_y      = opa_reg;
        add_sub    = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            rse_pkg::AST_IDLE: begin
                if (req.start) begin
                    op_next  = req.op;
                    opa_next = a;
                    opb_next = b;
                    acc_next = '0;
                    cnt_next = '0;
                    neg_next = a[W-1] ^ b[W-1];
                    unique case (req.op)
                        rse_pkg::ALU_ADD, rse_pkg::ALU_SUB: state_next = rse_pkg::AST_ADDSUB;
                        rse_pkg::ALU_MUL: state_next = rse_pkg::AST_MUL;
                        rse_pkg::ALU_DIV: state_next = rse_pkg::AST_NEGA;
                        default:          state_next = rse_pkg::AST_ADDSUB;
                    endcase
                end
            end
            rse_pkg::AST_ADDSUB: begin
                add_x      = opa_reg;
                add_y      = opb_reg;
                add_sub    = (op_reg == rse_pkg::ALU_SUB);
                acc_next   = sum[W-1:0];
                state_next = rse_pkg::AST_DONE;
            end
            rse_pkg::AST_MUL: begin
                // Add the shifted multiplicand for each set multiplier bit
                add_x = acc_reg;
                add_y = opa_reg;
                if (opb_reg[0]) begin
                    acc_next = sum[W-1:0];
                end
                opa_next = {opa_reg[W-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (last_step) begin
                    state_next = rse_pkg::AST_DONE;
                end
            end
            rse_pkg::AST_NEGA: begin
                // Take the dividend magnitude
                add_x   = '0;
                add_y   = opa_reg;
                add_sub = 1'b1;
                if (opa_reg[W-1]) begin
                    opa_next = sum[W-1:0];
                end
                state_next = rse_pkg::AST_NEGB;
            end
            rse_pkg::AST_NEGB: begin
                // Take the divisor magnitude
                add_x   = '0;
                add_y   = opb_reg;
                add_sub = 1'b1;
                if (opb_reg[W-1]) begin
                    opb_next = sum[W-1:0];
                end
                state_next = rse_pkg::AST_DIV;
            end
            rse_pkg::AST_DIV: begin
                // One restoring step: quotient bits shift into opa
                add_x    = rem_sh;
                add_y    = opb_reg;
                add_sub  = 1'b1;
                acc_next = sum[W] ? rem_sh : sum[W-1:0];
                opa_next = {opa_reg[W-2:0], ~sum[W]};
                cnt_next = cnt_reg + 1'b1;
                if (last_step) begin
                    state_next = rse_pkg::AST_FIX;
                end
            end
            rse_pkg::AST_FIX: begin
                // Apply the quotient sign
                add_x      = '0;
                add_y      = opa_reg;
                add_sub    = 1'b1;
                acc_next   = neg_reg ? sum[W-1:0] : opa_reg;
                state_next = rse_pkg::AST_DONE;
            end
            rse_pkg::AST_DONE: begin
                done       = 1'b1;
                state_next = rse_pkg::AST_IDLE;
            end
            default: begin
                state_next = rse_pkg::AST_IDLE;
            end
        endcase
    end

    assign result = acc_reg;

endmodule

/* src/rpn_stack_evaluator.sv */
// Top level of the RPN stack evaluator: token sequencer, operand stack and
// shared arithmetic unit. Depends on rse_pkg, rse_stack and rse_alu.
//
// Usage:
//   Tokens arrive on the s_ stream: s_tuser carries the token kind, s_tdata
//   the number value, s_tlast marks the final token of an expression. One
//   result per expression leaves on the m_ stream: m_tdata is the value,
//   m_tuser the status. prefix_mode is written through cfg_wr_en and
//   cfg_wr_data; the user must write it only while the block is idle, as
//   the block itself does not enforce this.
//   The block works on one token at a time and drops s_tready meanwhile.
//   Multiply and divide step bit-serially through the shared adder in
//   rse_alu. A last token passes the result check, and for a good result a
//   stack read, before the result is presented.
//   A result holds on m_tvalid/m_tdata/m_tuser until m_tready; no further
//   token is taken while it waits.
//   Reset (aresetn low, synchronous) empties the stack, clears the error
//   and prefix_mode, and returns to idle; no clearing pass is needed.
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = 128,
    parameter int DATA_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: prefix_mode
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // Token stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [30:0] token_value, [31] zero
    input  logic [2:0]  s_tuser,  // [2:0] token_kind
    input  logic        s_tlast,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [31:0] value
    output logic [2:0]  m_tuser   // [2:0] status
);

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int W       = DATA_WIDTH;
    localparam int TV_W    = rse_pkg::TOKEN_VALUE_W;
    localparam int RES_W   = rse_pkg::RESULT_W;

    rse_pkg::seq_state_t state_reg, state_next;
    logic [2:0]         kind_reg, kind_next;
    logic [W-1:0]       tval_reg, tval_next;
    logic               last_reg, last_next;
    logic               prefix_reg;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [2:0]         err_reg, err_next;
    logic [W-1:0]       first_reg, first_next;
    logic [RES_W-1:0]   value_reg, value_next;
    logic [2:0]         status_reg, status_next;

    logic [W-1:0]       tval_in;
    logic [RES_W-1:0]   rd_value;
    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_m2;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [W-1:0]       wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [W-1:0]       rd_data;

    rse_pkg::alu_req_t  alu_req;
    logic [W-1:0]       alu_a;
    logic [W-1:0]       alu_b;
    logic               alu_done;
    logic [W-1:0]       alu_result;

    // Fit the token value to the data width and the read value to the result width
    generate
        if (W > TV_W) begin : g_tv_ext
            assign tval_in = {{(W - TV_W){1'b0}}, s_tdata[TV_W-1:0]};
        end else begin : g_tv_trunc
            assign tval_in = s_tdata[W-1:0];
        end
        if (W >= RES_W) begin : g_res_trunc
            assign rd_value = rd_data[RES_W-1:0];
        end else begin : g_res_ext
            assign rd_value = {{(RES_W - W){rd_data[W-1]}}, rd_data};
        end
    endgenerate

    assign depth_m1 = depth_reg - 1'b1;
    assign depth_m2 = depth_reg - 2'd2;

    rse_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rse_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (alu_a),
        .b       (alu_b),
        .done    (alu_done),
        .result  (alu_result)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rse_pkg::SEQ_IDLE;
            depth_reg  <= '0;
            err_reg    <= rse_pkg::ST_OK;
            prefix_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            err_reg   <= err_next;
            if (cfg_wr_en) begin
                prefix_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        tval_reg   <= tval_next;
        last_reg   <= last_next;
        first_reg  <= first_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // Token sequencer
    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        tval_next   = tval_reg;
        last_next   = last_reg;
        depth_next  = depth_reg;
        err_next    = err_reg;
        first_next  = first_reg;
        value_next  = value_reg;
        status_next = status_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = depth_reg[ADDR_W-1:0];
        wr_data     = tval_reg;
        rd_en       = 1'b0;
        rd_addr     = depth_m1[ADDR_W-1:0];
        alu_req     = '{start: 1'b0, op: rse_pkg::ALU_ADD};
        alu_a       = prefix_reg ? first_reg : rd_data;
        alu_b       = prefix_reg ? rd_data : first_reg;
        unique case (state_reg)
            rse_pkg::SEQ_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    kind_next  = s_tuser;
                    tval_next  = tval_in;
                    last_next  = s_tlast;
                    state_next = rse_pkg::SEQ_EXEC;
                end
            end
            rse_pkg::SEQ_EXEC: begin
                state_next = rse_pkg::SEQ_CHECK;
                if (err_reg == rse_pkg::ST_OK) begin
                    priority if (kind_reg == rse_pkg::KIND_NUM) begin
                        // Push, or flag a full stack
                        if (depth_reg >= DEPTH_W'(STACK_DEPTH)) begin
                            err_next = rse_pkg::ST_OVER;
                        end else begin
                            wr_en      = 1'b1;
                            depth_next = depth_reg + 1'b1;
                        end
                    end else if (kind_reg >= rse_pkg::KIND_BAD) begin
                        err_next = rse_pkg::ST_BAD;
                    end else if (depth_reg < DEPTH_W'(2)) begin
                        err_next = rse_pkg::ST_UNDER;
                    end else begin
                        // Fetch the top entry
                        rd_en      = 1'b1;
                        rd_addr    = depth_m1[ADDR_W-1:0];
                        state_next = rse_pkg::SEQ_POP1;
                    end
                end
            end
            rse_pkg::SEQ_POP1: begin
                first_next = rd_data;
                rd_en      = 1'b1;
                rd_addr    = depth_m2[ADDR_W-1:0];
                state_next = rse_pkg::SEQ_POP2;
            end
            rse_pkg::SEQ_POP2: begin
                // Pop both operands, then start the unit or flag divide by zero
                depth_next = depth_m2;
                if (kind_reg == rse_pkg::KIND_DIV && alu_b == '0) begin
                    err_next   = rse_pkg::ST_DIV0;
                    state_next = rse_pkg::SEQ_CHECK;
                end else begin
                    alu_req.start = 1'b1;
                    unique case (kind_reg)
                        rse_pkg::KIND_ADD: alu_req.op = rse_pkg::ALU_ADD;
                        rse_pkg::KIND_SUB: alu_req.op = rse_pkg::ALU_SUB;
                        rse_pkg::KIND_MUL: alu_req.op = rse_pkg::ALU_MUL;
                        default:           alu_req.op = rse_pkg::ALU_DIV;
                    endcase
                    state_next = rse_pkg::SEQ_CALC;
                end
            end
            rse_pkg::SEQ_CALC: begin
                // Push the result when the unit finishes
                wr_data = alu_result;
                if (alu_done) begin
                    wr_en      = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    state_next = rse_pkg::SEQ_CHECK;
                end
            end
            rse_pkg::SEQ_CHECK: begin
                value_next = '0;
                priority if (!last_reg) begin
                    state_next = rse_pkg::SEQ_IDLE;
                end else if (err_reg != rse_pkg::ST_OK) begin
                    status_next = err_reg;
                    state_next  = rse_pkg::SEQ_OUT;
                end else if (depth_reg != DEPTH_W'(1)) begin
                    status_next = rse_pkg::ST_LEFT;
                    state_next  = rse_pkg::SEQ_OUT;
                end else begin
                    status_next = rse_pkg::ST_OK;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                    state_next  = rse_pkg::SEQ_READ0;
                end
            end
            rse_pkg::SEQ_READ0: begin
                value_next = rd_value;
                state_next = rse_pkg::SEQ_OUT;
            end
            rse_pkg::SEQ_OUT: begin
                // Hold the result; clear the expression once it is taken
                m_tvalid = 1'b1;
                if (m_tready) begin
                    depth_next = '0;
                    err_next   = rse_pkg::ST_OK;
                    state_next = rse_pkg::SEQ_IDLE;
                end
            end
            default: begin
                state_next = rse_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign m_tdata = value_reg;
    assign m_tuser = status_reg;

endmodule

/* src/rse_checker.sv */
// Port-level checker for the RPN stack evaluator, bound to the top level.
// Depends on rse_pkg and rpn_stack_evaluator_macros.svh.
`include "rpn_stack_evaluator_macros.svh"

module rse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // Stalled result holds
    `RSE_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Error results carry a zero value
    `RSE_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser != rse_pkg::ST_OK, m_tdata == 32'd0,
        "nonzero value with error status")

    // Status stays within the defined codes
    `RSE_ASSERT_NOW(a_status_range, m_tvalid, m_tuser <= rse_pkg::ST_LEFT,
        "status code out of range")

    // No token is taken while a result waits
    `RSE_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "token accepted with result pending")

    // An accepted item never produces a result in the next cycle
    `RSE_ASSERT_NEXT(a_min_latency, s_tvalid && s_tready, !m_tvalid,
        "result appeared one cycle after accept")

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* sim/tb.sv */
// Self-checking testbench for rpn_stack_evaluator: streams token expressions,
// predicts each result with a local stack evaluator and checks every result.
// Depends on rse_pkg and the rpn_stack_evaluator RTL.
module tb;

    localparam int          CLK_PERIOD  = 12;
    localparam int          STACK_N     = 128;
    localparam int          IDLE_PCT    = 28;
    localparam int          SETTLE_CYC  = 60;
    localparam logic [30:0] VAL_MAX     = 31'h7FFF_FFFF;
    // Kind codes that the block has no name for; both count as malformed
    localparam logic [2:0]  KIND_UNDEF6 = 3'd6;
    localparam logic [2:0]  KIND_UNDEF7 = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [30:0] val;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
    } eval_result_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;
    logic [2:0]  s_tuser     = '0;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    // Stimulus and prediction state
    token_t       token_q[$];
    token_t       tok_cur;
    eval_result_t eval_results_q[$];
    logic [31:0]  opnd_stack[STACK_N];
    int           opnd_depth  = 0;
    logic [2:0]   sticky_err  = rse_pkg::ST_OK;
    logic         order_prefix = 1'b0;
    logic         tok_fire    = 1'b0;

    // Run control
    int   run_phase   = 0;
    bit   steady_flow = 1'b0;
    bit   rx_hold     = 1'b0;
    int   fail_count  = 0;
    int   tokens_taken = 0;
    int   results_seen = 0;
    int   st_count[8];

    rpn_stack_evaluator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Push onto the predicted stack; a full stack reports overflow
    function automatic logic [2:0] stack_push(input logic [31:0] v);
        if (opnd_depth >= STACK_N) return rse_pkg::ST_OVER;
        opnd_stack[opnd_depth] = v;
        opnd_depth++;
        return rse_pkg::ST_OK;
    endfunction

    // Evaluate one accepted token and queue the result on a last token
    task automatic eval_token(input logic [2:0] kind, input logic [30:0] tval,
                              input logic last);
        logic [31:0]  top, below, lhs, rhs, res, mag_l, mag_r, quo;
        logic [2:0]   code;
        eval_result_t r;
        code = rse_pkg::ST_OK;
        res  = '0;
        if (sticky_err == rse_pkg::ST_OK) begin
            if (kind == rse_pkg::KIND_NUM) begin
                code = stack_push({1'b0, tval});
            end else if (kind > rse_pkg::KIND_DIV) begin
                code = rse_pkg::ST_BAD;
            end else if (opnd_depth < 2) begin
                code = rse_pkg::ST_UNDER;
            end else begin
                top   = opnd_stack[opnd_depth - 1];
                below = opnd_stack[opnd_depth - 2];
                opnd_depth -= 2;
                lhs = order_prefix ? top : below;
                rhs = order_prefix ? below : top;
                case (kind)
                    rse_pkg::KIND_ADD: res = lhs + rhs;
                    rse_pkg::KIND_SUB: res = lhs - rhs;
                    rse_pkg::KIND_MUL: res = lhs * rhs;
                    default: begin
                        if (rhs == '0) begin
                            code = rse_pkg::ST_DIV0;
                        end else begin
                            // Divide magnitudes, then fix the sign; wraps on min / -1
                            mag_l = lhs[31] ? -lhs : lhs;
                            mag_r = rhs[31] ? -rhs : rhs;
                            quo   = mag_l / mag_r;
                            res   = (lhs[31] ^ rhs[31]) ? -quo : quo;
                        end
                    end
                endcase
                if (code == rse_pkg::ST_OK) code = stack_push(res);
            end
            sticky_err = code;
        end
        if (last) begin
            r.value  = '0;
            r.status = sticky_err;
            if (sticky_err == rse_pkg::ST_OK) begin
                if (opnd_depth != 1) r.status = rse_pkg::ST_LEFT;
                else r.value = opnd_stack[0];
            end
            eval_results_q.push_back(r);
            opnd_depth = 0;
            sticky_err = rse_pkg::ST_OK;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_count++;
        $display("MISMATCH %s: expected 'h%08h got 'h%08h after %0d results",
                 what, want, got, results_seen);
    endtask

    // Track accepted items and feed them to the predictor
    always @(posedge aclk) begin
        tok_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            tokens_taken++;
            eval_token(s_tuser, s_tdata[30:0], s_tlast);
        end
    end

    // Drive the token stream; hold an offered item until it is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || tok_fire) begin
            if (token_q.size() != 0 && (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
                tok_cur = token_q.pop_front();
                s_tdata  <= {1'b0, tok_cur.val};
                s_tuser  <= tok_cur.kind;
                s_tlast  <= tok_cur.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Drive result back-pressure
    always @(negedge aclk) begin
        if (rx_hold) m_tready <= 1'b0;
        else if (steady_flow) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Check each result against the oldest prediction
    always @(posedge aclk) begin
        eval_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            st_count[m_tuser]++;
            if (eval_results_q.size() == 0) begin
                report_mismatch("unexpected result", '0, m_tdata);
            end else begin
                want = eval_results_q.pop_front();
                if (m_tdata !== want.value) report_mismatch("value", want.value, m_tdata);
                if (m_tuser !== want.status)
                    report_mismatch("status", {29'd0, want.status}, {29'd0, m_tuser});
            end
        end
    end

    // Hold off the result side for a long stretch during the steady phase
    initial begin
        while (run_phase != 2) @(posedge aclk);
        repeat (40) @(posedge aclk);
        rx_hold = 1'b1;
        repeat (400) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // Give up after a generous fixed time
    initial begin
        #(CLK_PERIOD * 600000);
        $display("rpn_stack_evaluator verification failed");
        $finish;
    end

    task automatic add_token(input logic [2:0] kind, input logic [30:0] val,
                             input logic last);
        token_t t;
        t.kind = kind;
        t.val  = val;
        t.last = last;
        token_q.push_back(t);
    endtask

    function automatic logic [30:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 31'd1;
            2:       return VAL_MAX;
            3, 4:    return 31'($urandom_range(0, 15));
            5, 6:    return 31'($urandom);
            7:       return 31'(1) << $urandom_range(0, 30);
            default: return 31'($urandom_range(0, 1000));
        endcase
    endfunction

    // Queue one expression: mostly well formed, sometimes damaged
    task automatic gen_expr(output int n_items);
        token_t expr[$];
        token_t t;
        int     pushes_left, depth, idx;
        pushes_left = (($urandom_range(0, 9) == 0) ? $urandom_range(5, 20)
                                                   : $urandom_range(0, 4)) + 1;
        depth = 0;
        while (pushes_left > 0 || depth > 1) begin
            t.last = 1'b0;
            if (pushes_left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
                t.kind = rse_pkg::KIND_NUM;
                t.val  = pick_operand();
                pushes_left--;
                depth++;
            end else begin
                t.kind = 3'($urandom_range(rse_pkg::KIND_ADD, rse_pkg::KIND_DIV));
                t.val  = 31'($urandom);
                depth--;
            end
            expr.push_back(t);
        end
        if ($urandom_range(0, 99) < 20) begin
            idx = $urandom_range(0, expr.size() - 1);
            case ($urandom_range(0, 3))
                0: if (expr.size() > 1) expr.delete(idx);
                1: expr[idx].kind = 3'($urandom_range(rse_pkg::KIND_BAD, KIND_UNDEF7));
                2: expr[idx].last = 1'b1;
                default: begin
                    // Pure noise: any kind, any value
                    expr.delete();
                    repeat ($urandom_range(1, 6)) begin
                        t.kind = 3'($urandom_range(rse_pkg::KIND_NUM, KIND_UNDEF7));
                        t.val  = 31'($urandom);
                        t.last = ($urandom_range(0, 4) == 0);
                        expr.push_back(t);
                    end
                end
            endcase
        end
        expr[expr.size() - 1].last = 1'b1;
        n_items = expr.size();
        foreach (expr[i]) token_q.push_back(expr[i]);
    endtask

    task automatic queue_random(input int target);
        int total, n;
        total = 0;
        while (total < target) begin
            gen_expr(n);
            total += n;
        end
    endtask

    // Fill the stack to the top, then push one too many on the last token
    task automatic queue_full_stack();
        for (int i = 0; i <= STACK_N; i++)
            add_token(rse_pkg::KIND_NUM, pick_operand(), i == STACK_N);
    endtask

    task automatic write_prefix_mode(input logic mode);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        order_prefix = mode;
    endtask

    // Wait until every item is taken and every result is back
    task automatic wait_idle();
        while (token_q.size() != 0 || s_tvalid || eval_results_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    initial begin
        foreach (st_count[i]) st_count[i] = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed checks in postfix order
        write_prefix_mode(1'b0);
        add_token(rse_pkg::KIND_NUM, VAL_MAX, 1'b1);
        add_token(rse_pkg::KIND_NUM, VAL_MAX, 1'b0);  // max + 1 wraps to min
        add_token(rse_pkg::KIND_NUM, 31'd1, 1'b0);
        add_token(rse_pkg::KIND_ADD, '0, 1'b0);
        add_token(rse_pkg::KIND_NUM, '0, 1'b0);       // 0 - 1 gives -1
        add_token(rse_pkg::KIND_NUM, 31'd1, 1'b0);
        add_token(rse_pkg::KIND_SUB, VAL_MAX, 1'b0);
        add_token(rse_pkg::KIND_DIV, '0, 1'b1);       // min / -1 wraps to min
        add_token(rse_pkg::KIND_NUM, VAL_MAX, 1'b0);
        add_token(rse_pkg::KIND_NUM, VAL_MAX, 1'b0);
        add_token(rse_pkg::KIND_MUL, '0, 1'b1);
        add_token(rse_pkg::KIND_NUM, 31'd5, 1'b0);
        add_token(rse_pkg::KIND_NUM, '0, 1'b0);
        add_token(rse_pkg::KIND_DIV, '0, 1'b1);       // divide by zero
        add_token(rse_pkg::KIND_ADD, '0, 1'b1);       // underflow on the last token
        add_token(KIND_UNDEF6, VAL_MAX, 1'b1);
        add_token(KIND_UNDEF7, '0, 1'b0);             // error, then the rest is ignored
        add_token(rse_pkg::KIND_NUM, 31'd3, 1'b1);
        add_token(rse_pkg::KIND_BAD, '0, 1'b1);
        add_token(rse_pkg::KIND_NUM, 31'd1, 1'b0);    // two operands left over
        add_token(rse_pkg::KIND_NUM, 31'd2, 1'b1);
        wait_idle();

        // Directed checks in prefix order: first pop is the left operand
        write_prefix_mode(1'b1);
        add_token(rse_pkg::KIND_NUM, 31'd7, 1'b0);
        add_token(rse_pkg::KIND_NUM, 31'd3, 1'b0);
        add_token(rse_pkg::KIND_SUB, '0, 1'b1);
        add_token(rse_pkg::KIND_NUM, 31'd2, 1'b0);
        add_token(rse_pkg::KIND_NUM, 31'd8, 1'b0);
        add_token(rse_pkg::KIND_DIV, '0, 1'b1);
        wait_idle();

        // Random expressions in prefix order with gaps on both sides
        run_phase = 1;
        queue_random(120);
        wait_idle();

        // Random expressions in postfix order, no gaps, long result stall
        write_prefix_mode(1'b0);
        run_phase   = 2;
        steady_flow = 1'b1;
        queue_random(120);
        wait_idle();
        steady_flow = 1'b0;

        // Full stack and overflow in prefix order
        write_prefix_mode(1'b1);
        run_phase = 3;
        queue_full_stack();
        wait_idle();

        $display("run covered %0d tokens and %0d results in both operand orders",
                 tokens_taken, results_seen);
        $display("statuses: ok %0d, underflow %0d, overflow %0d, div0 %0d, bad %0d, left %0d",
                 st_count[rse_pkg::ST_OK], st_count[rse_pkg::ST_UNDER],
                 st_count[rse_pkg::ST_OVER], st_count[rse_pkg::ST_DIV0],
                 st_count[rse_pkg::ST_BAD], st_count[rse_pkg::ST_LEFT]);
        if (fail_count == 0) begin
            $display("rpn_stack_evaluator verification clean");
        end else begin
            $display("rpn_stack_evaluator verification failed");
        end
        $finish;
    end

endmodule
